/* rtl/sdrc_pkg.sv */
// Package for the slot allocator with dirty-run coalescing.
// Holds sizes, request codes, word layouts and controller/datapath structs.
// No dependencies.
package sdrc_pkg;

   // Slot pool size and region limit per commit
   localparam int ENTRIES      = 64;
   localparam int MAX_RESULTS  = 32;

   // Internal widths follow the pool size
   localparam int SLOT_W       = $clog2(ENTRIES);
   localparam int CNT_W        = $clog2(ENTRIES + 1);
   localparam int REGION_CNT_W = $clog2(MAX_RESULTS + 1);

   // Fixed word field widths
   localparam int REQ_TYPE_W   = 2;
   localparam int IN_SLOT_W    = 6;
   localparam int OUT_SLOT_W   = 6;
   localparam int OUT_LEN_W    = 7;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_FREE   = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_UPDATE = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_COMMIT = 2'd3;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [IN_SLOT_W-1:0]  slot;
   } sdrc_req_word_type;

   typedef struct packed {
      logic                  ok;
      logic [OUT_SLOT_W-1:0] given_slot;
      logic                  pending;
      logic                  region_valid;
      logic [OUT_SLOT_W-1:0] staging_start;
      logic [OUT_SLOT_W-1:0] dest_start;
      logic [OUT_LEN_W-1:0]  run_length;
      logic                  last;
   } sdrc_rsp_word_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;   // latch incoming word, reset scan state
      logic exec;     // carry out allocate, free or update and emit its word
      logic step;     // examine one slot of the commit scan
      logic close;    // close the open run after the last slot
      logic fin;      // emit the final commit word
   } sdrc_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;
      logic new_commit;
      logic scan_last;
      logic in_run;
   } sdrc_status_type;

   // Queue pointer advance with wrap at the pool size
   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] ptr);
      logic [SLOT_W-1:0] nxt;
      if (ptr == SLOT_W'(ENTRIES - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

endpackage

/* rtl/sdrc_chan_if.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on sdrc_pkg for the word layouts.
interface sdrc_req_if import sdrc_pkg::*; ();
   logic              valid;
   logic              ready;
   sdrc_req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sdrc_rsp_if import sdrc_pkg::*; ();
   logic              valid;
   logic              ready;
   sdrc_rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/sdrc_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module sdrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sdrc_ctrl.sv */
// Sequencer for the slot allocator: accepts words, runs ops and the commit scan.
// Depends on sdrc_pkg for command and status structs.
module sdrc_ctrl import sdrc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  sdrc_status_type status,
   output sdrc_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.new_commit ? ST_SCAN : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.out_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.scan_last) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               if (status.in_run) begin
                  cmd.close = 1'b1;
               end else begin
                  cmd.fin  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // At most one command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.exec, cmd.step, cmd.close, cmd.fin}))
      else $error("sdrc_ctrl: more than one command");

   // Words are only taken while idle
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> (state_ff == ST_IDLE))
      else $error("sdrc_ctrl: word taken outside idle");

   // A scan step on the last slot is followed by the flush phase
   a_scan_to_flush: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && status.scan_last) |=> (state_ff == ST_FLUSH))
      else $error("sdrc_ctrl: scan did not move to flush");

endmodule

/* rtl/sdrc_dp.sv */
// Datapath: free queue, active/changed flags, run coalescing and output register.
// Depends on sdrc_pkg and sdrc_ram.
module sdrc_dp import sdrc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  sdrc_req_word_type req_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output sdrc_rsp_word_type rsp_data,
   input  sdrc_cmd_type      cmd,
   output sdrc_status_type   status
);

   // Request latch
   sdrc_req_word_type req_ff, req_in;

   // Free queue pointers, occupancy and count of queue entries ever written
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;

   // Slot flags
   logic [ENTRIES-1:0] active_ff, active_in;
   logic [ENTRIES-1:0] changed_ff, changed_in;
   logic               any_ff, any_in;

   // Scan state
   logic [SLOT_W-1:0]       idx_ff, idx_in;
   logic                    in_run_ff, in_run_in;
   logic [CNT_W-1:0]        written_ff, written_in;
   logic [CNT_W-1:0]        run_stg_ff, run_stg_in;
   logic [SLOT_W-1:0]       run_dst_ff, run_dst_in;
   logic [CNT_W-1:0]        run_len_ff, run_len_in;
   logic                    held_valid_ff, held_valid_in;
   logic [CNT_W-1:0]        held_stg_ff, held_stg_in;
   logic [SLOT_W-1:0]       held_dst_ff, held_dst_in;
   logic [CNT_W-1:0]        held_len_ff, held_len_in;
   logic [REGION_CNT_W-1:0] region_cnt_ff, region_cnt_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   sdrc_rsp_word_type rsp_data_ff, rsp_data_in;

   // Queue memory
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_rd_data;

   logic              out_free;
   logic              push;
   sdrc_rsp_word_type push_word;
   logic              slot_in_range;
   logic [SLOT_W-1:0] slot_idx;
   logic [SLOT_W-1:0] alloc_slot;
   logic              dirty;
   logic              do_close;

   sdrc_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (ENTRIES)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (slot_idx),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign slot_in_range = (32'(req_ff.slot) < ENTRIES);
   assign slot_idx      = SLOT_W'(req_ff.slot);
   // Queue positions not yet written still hold their reset index
   assign alloc_slot    = (CNT_W'(head_ff) < fill_ff) ? ram_rd_data : head_ff;
   assign dirty         = active_ff[idx_ff] && changed_ff[idx_ff];
   assign do_close      = (cmd.step && in_run_ff && !dirty) || cmd.close;

   assign status.out_free   = out_free;
   assign status.new_commit = (req_data.req_type == REQ_COMMIT);
   assign status.scan_last  = (idx_ff == SLOT_W'(ENTRIES - 1));
   assign status.in_run     = in_run_ff;

   // Operation and scan logic
   always_comb begin
      req_in        = req_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      fill_in       = fill_ff;
      active_in     = active_ff;
      changed_in    = changed_ff;
      any_in        = any_ff;
      idx_in        = idx_ff;
      in_run_in     = in_run_ff;
      written_in    = written_ff;
      run_stg_in    = run_stg_ff;
      run_dst_in    = run_dst_ff;
      run_len_in    = run_len_ff;
      held_valid_in = held_valid_ff;
      held_stg_in   = held_stg_ff;
      held_dst_in   = held_dst_ff;
      held_len_in   = held_len_ff;
      region_cnt_in = region_cnt_ff;
      ram_wr_en     = 1'b0;
      push          = 1'b0;
      push_word     = '0;

      // New word: latch it and restart the scan state
      if (cmd.accept) begin
         req_in        = req_data;
         idx_in        = '0;
         in_run_in     = 1'b0;
         written_in    = '0;
         held_valid_in = 1'b0;
         region_cnt_in = '0;
         if (req_data.req_type == REQ_COMMIT) begin
            any_in = 1'b0;
         end
      end

      // Single word operations
      if (cmd.exec) begin
         push           = 1'b1;
         push_word.last = 1'b1;
         unique case (req_ff.req_type)
            REQ_ALLOC: begin
               if (count_ff != '0) begin
                  push_word.ok         = 1'b1;
                  push_word.given_slot = OUT_SLOT_W'(alloc_slot);
                  head_in              = slot_inc(head_ff);
                  count_in             = count_ff - 1'b1;
                  active_in[alloc_slot] = 1'b1;
                  any_in               = 1'b1;
               end
            end
            REQ_FREE: begin
               if (slot_in_range && active_ff[slot_idx] &&
                   (32'(count_ff) < ENTRIES)) begin
                  push_word.ok        = 1'b1;
                  ram_wr_en           = 1'b1;
                  tail_in             = slot_inc(tail_ff);
                  count_in            = count_ff + 1'b1;
                  active_in[slot_idx] = 1'b0;
                  any_in              = 1'b1;
                  if (32'(fill_ff) < ENTRIES) begin
                     fill_in = fill_ff + 1'b1;
                  end
               end
            end
            REQ_UPDATE: begin
               if (slot_in_range) begin
                  push_word.ok         = 1'b1;
                  changed_in[slot_idx] = 1'b1;
                  any_in               = 1'b1;
               end
            end
            REQ_COMMIT: begin
               push = 1'b0;
            end
         endcase
         push_word.pending = any_in;
      end

      // One slot of the commit scan
      if (cmd.step) begin
         changed_in[idx_ff] = 1'b0;
         idx_in             = idx_ff + 1'b1;
         if (dirty) begin
            written_in = written_ff + 1'b1;
            if (in_run_ff) begin
               run_len_in = run_len_ff + 1'b1;
            end else begin
               in_run_in  = 1'b1;
               run_stg_in = written_ff;
               run_dst_in = idx_ff;
               run_len_in = CNT_W'(1);
            end
         end
      end

      // Close a run below the region limit: the held region goes out, the new one is held
      if (do_close) begin
         in_run_in = 1'b0;
         if (32'(region_cnt_ff) < MAX_RESULTS) begin
            if (held_valid_ff) begin
               push                    = 1'b1;
               push_word.ok            = 1'b1;
               push_word.region_valid  = 1'b1;
               push_word.staging_start = OUT_SLOT_W'(held_stg_ff);
               push_word.dest_start    = OUT_SLOT_W'(held_dst_ff);
               push_word.run_length    = OUT_LEN_W'(held_len_ff);
            end
            held_valid_in = 1'b1;
            held_stg_in   = run_stg_ff;
            held_dst_in   = run_dst_ff;
            held_len_in   = run_len_ff;
            region_cnt_in = region_cnt_ff + 1'b1;
         end
      end

      // Final commit word
      if (cmd.fin) begin
         push              = 1'b1;
         push_word.ok      = 1'b1;
         push_word.last    = 1'b1;
         push_word.pending = any_ff;
         if (held_valid_ff) begin
            push_word.region_valid  = 1'b1;
            push_word.staging_start = OUT_SLOT_W'(held_stg_ff);
            push_word.dest_start    = OUT_SLOT_W'(held_dst_ff);
            push_word.run_length    = OUT_LEN_W'(held_len_ff);
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push_word;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= CNT_W'(ENTRIES);
         fill_ff       <= '0;
         active_ff     <= '0;
         changed_ff    <= '0;
         any_ff        <= 1'b0;
         in_run_ff     <= 1'b0;
         held_valid_ff <= 1'b0;
         region_cnt_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         fill_ff       <= fill_in;
         active_ff     <= active_in;
         changed_ff    <= changed_in;
         any_ff        <= any_in;
         in_run_ff     <= in_run_in;
         held_valid_ff <= held_valid_in;
         region_cnt_ff <= region_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      written_ff  <= written_in;
      run_stg_ff  <= run_stg_in;
      run_dst_ff  <= run_dst_in;
      run_len_ff  <= run_len_in;
      held_stg_ff <= held_stg_in;
      held_dst_ff <= held_dst_in;
      held_len_ff <= held_len_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Every slot is either queued or active, never both
   a_slot_conservation: assert property (@(posedge clock) disable iff (reset)
      ($countones(active_ff) + 32'(count_ff)) == ENTRIES)
      else $error("sdrc_dp: queued plus active slots differ from pool size");

   // A word is only loaded when the output register can take it
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("sdrc_dp: output register overwritten");

   // After a commit finishes no slot is left marked changed
   a_commit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> (changed_ff == '0) && !any_ff)
      else $error("sdrc_dp: commit left changed flags set");

endmodule

/* rtl/slot_allocator_dirty_run_coalescer.sv */
// Top level of the slot allocator with dirty-run coalescing.
// Depends on sdrc_pkg, sdrc_chan_if, sdrc_ctrl, sdrc_dp (and sdrc_ram).
//
//  channel    dir  word                            handshake
//  req_chan   in   req_type, slot                  valid/ready
//  rsp_chan   out  ok, given_slot, pending,        valid/ready
//                  region_valid, staging_start,
//                  dest_start, run_length, last
//
// Allocate, free and update take the word in the idle state and act on it in
// the exec state, where the queue RAM read of the head entry is already registered.
// Commit steps one slot per cycle through the flag vectors while the output
// register is free, then closes any open run and emits the final region word.
// Synchronous reset restores the queue state at once; no clearing pass.
// A stalled response holds the sequencer; one finished word may wait in the
// output register while the next request word is taken.
module slot_allocator_dirty_run_coalescer import sdrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sdrc_req_if.sink   req_chan,
   sdrc_rsp_if.source rsp_chan
);

   sdrc_cmd_type    cmd;
   sdrc_status_type status;
   logic            req_ready;
   logic            rsp_valid;
   sdrc_rsp_word_type rsp_data;

   sdrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sdrc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_chan.data),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.data  = rsp_data;

endmodule
